// ===== rtl/nec_ir_pulse_decoder_unit_defines.svh =====
// Assertion macros used by the NEC IR decoder core.
`ifndef NEC_IR_PULSE_DECODER_UNIT_DEFINES_SVH
`define NEC_IR_PULSE_DECODER_UNIT_DEFINES_SVH

// Same-cycle implication, disabled during reset.
`define NIR_ASSERT_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, disabled during reset.
`define NIR_ASSERT_NXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== rtl/nec_ir_pkg.sv =====
// Types and constants for the NEC IR pulse decoder.
package nec_ir_pkg;

  localparam int unsigned TimeW  = 16;
  localparam int unsigned TmoW   = 4;
  localparam int unsigned FrameW = 32;
  localparam int unsigned CntW   = 8;
  localparam int unsigned CfgIdxW = 3;

  // ticks counted after the last repeat; the tick after that drops the lead flag
  localparam logic [TmoW-1:0] TIMEOUT_LIMIT = 4'd13;

  typedef enum logic [1:0] {
    OP_TICK = 2'd0,
    OP_RISE = 2'd1,
    OP_FALL = 2'd2,
    OP_READ = 2'd3
  } op_t;

  typedef enum logic [CfgIdxW-1:0] {
    REG_ZERO_MIN   = 3'd0,
    REG_ZERO_MAX   = 3'd1,
    REG_ONE_MIN    = 3'd2,
    REG_ONE_MAX    = 3'd3,
    REG_REPEAT_MIN = 3'd4,
    REG_REPEAT_MAX = 3'd5,
    REG_LEAD_MIN   = 3'd6,
    REG_LEAD_MAX   = 3'd7
  } cfg_reg_t;

  localparam logic [TimeW-1:0] ZERO_MIN_RST   = 16'd400;
  localparam logic [TimeW-1:0] ZERO_MAX_RST   = 16'd700;
  localparam logic [TimeW-1:0] ONE_MIN_RST    = 16'd1500;
  localparam logic [TimeW-1:0] ONE_MAX_RST    = 16'd1800;
  localparam logic [TimeW-1:0] REPEAT_MIN_RST = 16'd2350;
  localparam logic [TimeW-1:0] REPEAT_MAX_RST = 16'd2650;
  localparam logic [TimeW-1:0] LEAD_MIN_RST   = 16'd4300;
  localparam logic [TimeW-1:0] LEAD_MAX_RST   = 16'd4700;

  typedef struct packed {
    logic [TimeW-1:0] zero_min;
    logic [TimeW-1:0] zero_max;
    logic [TimeW-1:0] one_min;
    logic [TimeW-1:0] one_max;
    logic [TimeW-1:0] repeat_min;
    logic [TimeW-1:0] repeat_max;
    logic [TimeW-1:0] lead_min;
    logic [TimeW-1:0] lead_max;
  } thr_t;

  // pulse window hits, each bound exclusive
  typedef struct packed {
    logic zero;
    logic one;
    logic rpt;
    logic lead;
  } pulse_hit_t;

endpackage

// ===== rtl/nec_ir_cfg.sv =====
// Threshold register file for the NEC IR decoder.
module nec_ir_cfg (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         cfg_we,
  input  logic [nec_ir_pkg::CfgIdxW-1:0] cfg_index,
  input  logic [nec_ir_pkg::TimeW-1:0] cfg_wdata,
  output nec_ir_pkg::thr_t             thr
);
  import nec_ir_pkg::*;

  thr_t thr_r;
  thr_t thr_nxt;

  always_comb begin
    thr_nxt = thr_r;
    if (cfg_we) begin
      unique case (cfg_reg_t'(cfg_index))
        REG_ZERO_MIN:   thr_nxt.zero_min   = cfg_wdata;
        REG_ZERO_MAX:   thr_nxt.zero_max   = cfg_wdata;
        REG_ONE_MIN:    thr_nxt.one_min    = cfg_wdata;
        REG_ONE_MAX:    thr_nxt.one_max    = cfg_wdata;
        REG_REPEAT_MIN: thr_nxt.repeat_min = cfg_wdata;
        REG_REPEAT_MAX: thr_nxt.repeat_max = cfg_wdata;
        REG_LEAD_MIN:   thr_nxt.lead_min   = cfg_wdata;
        REG_LEAD_MAX:   thr_nxt.lead_max   = cfg_wdata;
        default:        thr_nxt = thr_r;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      thr_r.zero_min   <= ZERO_MIN_RST;
      thr_r.zero_max   <= ZERO_MAX_RST;
      thr_r.one_min    <= ONE_MIN_RST;
      thr_r.one_max    <= ONE_MAX_RST;
      thr_r.repeat_min <= REPEAT_MIN_RST;
      thr_r.repeat_max <= REPEAT_MAX_RST;
      thr_r.lead_min   <= LEAD_MIN_RST;
      thr_r.lead_max   <= LEAD_MAX_RST;
    end else begin
      thr_r <= thr_nxt;
    end
  end

  assign thr = thr_r;

endmodule

// ===== rtl/nec_ir_classify.sv =====
// Window compares of a measured high time against the pulse thresholds.
module nec_ir_classify (
  input  logic [nec_ir_pkg::TimeW-1:0] high_time,
  input  nec_ir_pkg::thr_t             thr,
  output nec_ir_pkg::pulse_hit_t       hit
);
  import nec_ir_pkg::*;

  assign hit.zero = (high_time > thr.zero_min)   && (high_time < thr.zero_max);
  assign hit.one  = (high_time > thr.one_min)    && (high_time < thr.one_max);
  assign hit.rpt  = (high_time > thr.repeat_min) && (high_time < thr.repeat_max);
  assign hit.lead = (high_time > thr.lead_min)   && (high_time < thr.lead_max);

endmodule

// ===== rtl/nec_ir_core.sv =====
// Decoder state update and result register.
`include "nec_ir_pulse_decoder_unit_defines.svh"

module nec_ir_core (
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   item_vld,
  input  nec_ir_pkg::op_t        item_op,
  input  nec_ir_pkg::pulse_hit_t hit,
  output logic                   item_take,
  output logic                   out_tvalid,
  input  logic                   out_tready,
  output logic                   key_valid,
  output logic [7:0]             key_code,
  output logic [nec_ir_pkg::CntW-1:0] repeat_total,
  output logic                   lead_active
);
  import nec_ir_pkg::*;

  logic              lead_flag_r, lead_flag_nxt;
  logic              edge_armed_r, edge_armed_nxt;
  logic [TmoW-1:0]   timeout_r, timeout_nxt;
  logic [FrameW-1:0] frame_r, frame_nxt;
  logic [CntW-1:0]   rpt_cnt_r, rpt_cnt_nxt;

  logic              out_vld_r;
  logic              key_valid_r, key_valid_nxt;
  logic [7:0]        key_code_r, key_code_nxt;
  logic [CntW-1:0]   out_rpt_r;
  logic              out_lead_r;

  logic [7:0] addr_b, addr_n_b, data_b, data_n_b;
  logic       addr_ok, data_ok;

  assign item_take = item_vld && (!out_vld_r || out_tready);

  assign addr_b   = frame_r[31:24];
  assign addr_n_b = frame_r[23:16];
  assign data_b   = frame_r[15:8];
  assign data_n_b = frame_r[7:0];
  assign addr_ok  = (addr_b == ~addr_n_b);
  assign data_ok  = (data_b == ~data_n_b);

  always_comb begin
    lead_flag_nxt  = lead_flag_r;
    edge_armed_nxt = edge_armed_r;
    timeout_nxt    = timeout_r;
    frame_nxt      = frame_r;
    rpt_cnt_nxt    = rpt_cnt_r;
    key_valid_nxt  = 1'b0;
    key_code_nxt   = '0;
    unique case (item_op)
      OP_TICK: begin
        if (lead_flag_r) begin
          edge_armed_nxt = 1'b0;
          if (timeout_r < TIMEOUT_LIMIT) begin
            timeout_nxt = timeout_r + 1'b1;
          end else begin
            lead_flag_nxt = 1'b0;
            timeout_nxt   = '0;
          end
        end
      end
      OP_RISE: begin
        edge_armed_nxt = 1'b1;
      end
      OP_FALL: begin
        edge_armed_nxt = 1'b0;
        if (edge_armed_r) begin
          if (lead_flag_r) begin
            // zero wins over one, one over repeat
            priority if (hit.zero) begin
              frame_nxt = {frame_r[FrameW-2:0], 1'b0};
            end else if (hit.one) begin
              frame_nxt = {frame_r[FrameW-2:0], 1'b1};
            end else if (hit.rpt) begin
              rpt_cnt_nxt = rpt_cnt_r + 1'b1;
              timeout_nxt = '0;
            end
          end else if (hit.lead) begin
            lead_flag_nxt = 1'b1;
            rpt_cnt_nxt   = '0;
          end
        end
      end
      OP_READ: begin
        if (addr_ok && data_ok) begin
          key_valid_nxt = 1'b1;
          key_code_nxt  = data_b;
        end else if (!data_ok || !lead_flag_r) begin
          lead_flag_nxt  = 1'b0;
          edge_armed_nxt = 1'b0;
          timeout_nxt    = '0;
        end
      end
      default: begin
        lead_flag_nxt = lead_flag_r;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      lead_flag_r  <= 1'b0;
      edge_armed_r <= 1'b0;
      timeout_r    <= '0;
      frame_r      <= '0;
      rpt_cnt_r    <= '0;
      out_vld_r    <= 1'b0;
    end else begin
      if (item_take) begin
        lead_flag_r  <= lead_flag_nxt;
        edge_armed_r <= edge_armed_nxt;
        timeout_r    <= timeout_nxt;
        frame_r      <= frame_nxt;
        rpt_cnt_r    <= rpt_cnt_nxt;
        out_vld_r    <= 1'b1;
      end else if (out_tready) begin
        out_vld_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (item_take) begin
      key_valid_r <= key_valid_nxt;
      key_code_r  <= key_code_nxt;
      out_rpt_r   <= rpt_cnt_nxt;
      out_lead_r  <= lead_flag_nxt;
    end
  end

  assign out_tvalid   = out_vld_r;
  assign key_valid    = key_valid_r;
  assign key_code     = key_code_r;
  assign repeat_total = out_rpt_r;
  assign lead_active  = out_lead_r;

  `NIR_ASSERT_IMP(a_code_zero_wo_key, out_vld_r && !key_valid_r, key_code_r == '0, "key code without valid key")
  `NIR_ASSERT_IMP(a_tmo_idle, !lead_flag_r, timeout_r == '0, "timeout counting without lead")
  `NIR_ASSERT_IMP(a_tmo_limit, lead_flag_r, timeout_r <= TIMEOUT_LIMIT, "timeout past limit")
  `NIR_ASSERT_IMP(a_lead_clears_rpt, $rose(lead_flag_r), rpt_cnt_r == '0, "repeat count kept on lead")
  `NIR_ASSERT_NXT(a_rise_arms, item_take && (item_op == OP_RISE), edge_armed_r, "rising edge did not arm")

endmodule

// ===== rtl/nec_ir_pulse_decoder_unit.sv =====
// NEC IR pulse decoder: one event in per cycle unless out_tready stalls it, one result per event.
// Each input transaction passes the input register, then the result register, to its result.
// Throughput: one event per cycle unless stalled; the result register stalls only on out_tready low.
// Reset (rst_n low, synchronous): decoder state cleared, thresholds back to defaults.
module nec_ir_pulse_decoder_unit (
  input  logic        clk,
  input  logic        rst_n,
  // configuration
  input  logic        cfg_we,
  input  logic [nec_ir_pkg::CfgIdxW-1:0] cfg_index,
  input  logic [nec_ir_pkg::TimeW-1:0]   cfg_wdata,
  // event stream
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [15:0] in_tdata,   // [15:0] high_time
  input  logic [1:0]  in_tuser,   // [1:0] opcode
  // result stream
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [23:0] out_tdata   // [0] key_valid, [8:1] key_code,
                                  // [16:9] repeat_total, [17] lead_active, rest 0
);
  import nec_ir_pkg::*;

  logic             in_vld_r;
  op_t              in_op_r;
  logic [TimeW-1:0] in_time_r;
  logic             item_take;

  thr_t       thr;
  pulse_hit_t hit;

  logic             key_valid;
  logic [7:0]       key_code;
  logic [CntW-1:0]  repeat_total;
  logic             lead_active;

  assign in_tready = !in_vld_r || item_take;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_vld_r <= 1'b0;
    end else if (in_tready) begin
      in_vld_r <= in_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_tvalid && in_tready) begin
      in_op_r   <= op_t'(in_tuser);
      in_time_r <= in_tdata;
    end
  end

  nec_ir_cfg u_cfg (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata),
    .thr       (thr)
  );

  nec_ir_classify u_classify (
    .high_time (in_time_r),
    .thr       (thr),
    .hit       (hit)
  );

  nec_ir_core u_core (
    .clk          (clk),
    .rst_n        (rst_n),
    .item_vld     (in_vld_r),
    .item_op      (in_op_r),
    .hit          (hit),
    .item_take    (item_take),
    .out_tvalid   (out_tvalid),
    .out_tready   (out_tready),
    .key_valid    (key_valid),
    .key_code     (key_code),
    .repeat_total (repeat_total),
    .lead_active  (lead_active)
  );

  assign out_tdata = {6'd0, lead_active, repeat_total, key_code, key_valid};

endmodule

// ===== tb/tb_nec_ir_pulse_decoder_unit.sv =====
// Testbench for the NEC IR pulse decoder: event stream in, checked result stream out.
`timescale 1ns / 100ps

module tb_nec_ir_pulse_decoder_unit;
  import nec_ir_pkg::*;

  localparam int WATCHDOG_LIMIT = 3000;
  localparam int LONG_HOLD      = 150;

  typedef struct packed {
    logic       key_valid;
    logic [7:0] key_code;
    logic [7:0] repeat_total;
    logic       lead_active;
  } ir_result_t;

  logic                 clk;
  logic                 rst_n      = 1'b0;
  logic                 cfg_we     = 1'b0;
  logic [CfgIdxW-1:0]   cfg_index  = '0;
  logic [TimeW-1:0]     cfg_wdata  = '0;
  logic                 in_tvalid  = 1'b0;
  logic                 in_tready;
  logic [15:0]          in_tdata   = '0;
  logic [1:0]           in_tuser   = '0;
  logic                 out_tvalid;
  logic                 out_tready = 1'b0;
  logic [23:0]          out_tdata;

  // decoder state mirrored by the predictor
  logic [TimeW-1:0]  thr [8];
  logic              lead_flag;
  logic              edge_armed;
  logic [TmoW-1:0]   timeout_ticks;
  logic [FrameW-1:0] frame_shift;
  logic [CntW-1:0]   repeat_count;

  ir_result_t pending_results[$];
  int         mismatches   = 0;
  int         items_sent   = 0;
  int         in_idle_pct  = 0;
  int         out_idle_pct = 0;
  int         hold_request = 0;
  int         hold_left    = 0;
  int         quiet_cycles = 0;

  nec_ir_pulse_decoder_unit i_dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_tdata  (in_tdata),   // [15:0] high_time
    .in_tuser  (in_tuser),   // [1:0] opcode
    .out_tvalid(out_tvalid),
    .out_tready(out_tready),
    .out_tdata (out_tdata)   // [0] key_valid, [8:1] key_code, [16:9] repeat_total,
                             // [17] lead_active, [23:18] zero
  );

  always begin
    clk = 1'b0;
    #10;
    clk = 1'b1;
    #10;
  end

  function automatic logic in_window(cfg_reg_t lo, cfg_reg_t hi, logic [TimeW-1:0] t);
    return (t > thr[lo]) && (t < thr[hi]);
  endfunction

  function automatic ir_result_t decode_event(op_t op, logic [TimeW-1:0] t);
    ir_result_t r;
    logic       addr_ok;
    logic       data_ok;
    r = '0;
    case (op)
      OP_TICK: begin
        if (lead_flag) begin
          edge_armed = 1'b0;
          if (timeout_ticks < TIMEOUT_LIMIT) begin
            timeout_ticks = timeout_ticks + 1'b1;
          end else begin
            lead_flag     = 1'b0;
            timeout_ticks = '0;
          end
        end
      end
      OP_RISE: edge_armed = 1'b1;
      OP_FALL: begin
        if (edge_armed) begin
          if (lead_flag) begin
            // zero window has priority over one, one over repeat
            if (in_window(REG_ZERO_MIN, REG_ZERO_MAX, t)) begin
              frame_shift = {frame_shift[FrameW-2:0], 1'b0};
            end else if (in_window(REG_ONE_MIN, REG_ONE_MAX, t)) begin
              frame_shift = {frame_shift[FrameW-2:0], 1'b1};
            end else if (in_window(REG_REPEAT_MIN, REG_REPEAT_MAX, t)) begin
              repeat_count  = repeat_count + 1'b1;
              timeout_ticks = '0;
            end
          end else if (in_window(REG_LEAD_MIN, REG_LEAD_MAX, t)) begin
            lead_flag    = 1'b1;
            repeat_count = '0;
          end
        end
        edge_armed = 1'b0;
      end
      default: begin
        addr_ok = frame_shift[31:24] == ~frame_shift[23:16];
        data_ok = frame_shift[15:8] == ~frame_shift[7:0];
        if (addr_ok && data_ok) begin
          r.key_valid = 1'b1;
          r.key_code  = frame_shift[15:8];
        end else if (!data_ok || !lead_flag) begin
          lead_flag     = 1'b0;
          edge_armed    = 1'b0;
          timeout_ticks = '0;
        end
      end
    endcase
    r.repeat_total = repeat_count;
    r.lead_active  = lead_flag;
    return r;
  endfunction

  // result checker
  always @(posedge clk) begin
    ir_result_t want;
    if (rst_n && out_tvalid && out_tready) begin
      if (pending_results.size() == 0) begin
        $error("result transaction with none expected: %h", out_tdata);
        mismatches++;
      end else begin
        want = pending_results.pop_front();
        if (out_tdata[0] !== want.key_valid) begin
          $error("key_valid: expected %0d, actual %0d", want.key_valid, out_tdata[0]);
          mismatches++;
        end
        if (out_tdata[8:1] !== want.key_code) begin
          $error("key_code: expected %0d, actual %0d", want.key_code, out_tdata[8:1]);
          mismatches++;
        end
        if (out_tdata[16:9] !== want.repeat_total) begin
          $error("repeat_total: expected %0d, actual %0d", want.repeat_total,
                 out_tdata[16:9]);
          mismatches++;
        end
        if (out_tdata[17] !== want.lead_active) begin
          $error("lead_active: expected %0d, actual %0d", want.lead_active, out_tdata[17]);
          mismatches++;
        end
        if (out_tdata[23:18] !== 6'd0) begin
          $error("padding: expected 0, actual %0d", out_tdata[23:18]);
          mismatches++;
        end
      end
    end
  end

  // receiver: random stalls plus an occasional long hold-off
  always @(posedge clk) begin
    if (hold_request > 0) begin
      hold_left    = hold_request;
      hold_request = 0;
    end
    if (hold_left > 0) begin
      hold_left--;
      out_tready <= 1'b0;
    end else begin
      out_tready <= ($urandom_range(99) >= out_idle_pct);
    end
  end

  always @(posedge clk) begin
    if ((in_tvalid && in_tready) || (out_tvalid && out_tready)) begin
      quiet_cycles = 0;
    end else begin
      quiet_cycles++;
    end
    if (quiet_cycles >= WATCHDOG_LIMIT) begin
      $display("status: fail");
      $finish;
    end
  end

  task automatic send_event(op_t op, logic [TimeW-1:0] t);
    while ($urandom_range(99) < in_idle_pct) begin
      in_tvalid <= 1'b0;
      @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tuser  <= op;
    in_tdata  <= t;
    do @(posedge clk); while (!in_tready);
    pending_results.push_back(decode_event(op, t));
    items_sent++;
  endtask

  task automatic send_pulse(logic [TimeW-1:0] t);
    send_event(OP_RISE, 16'($urandom));
    send_event(OP_FALL, t);
  endtask

  // transaction stream quiet and every result in before the next phase
  task automatic wait_idle();
    in_tvalid <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic write_reg(cfg_reg_t idx, logic [TimeW-1:0] v);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= v;
    @(posedge clk);
    thr[idx] = v;
  endtask

  task automatic load_thresholds(logic [TimeW-1:0] zmin, zmax, omin, omax,
                                 rmin, rmax, lmin, lmax);
    write_reg(REG_ZERO_MIN, zmin);
    write_reg(REG_ZERO_MAX, zmax);
    write_reg(REG_ONE_MIN, omin);
    write_reg(REG_ONE_MAX, omax);
    write_reg(REG_REPEAT_MIN, rmin);
    write_reg(REG_REPEAT_MAX, rmax);
    write_reg(REG_LEAD_MIN, lmin);
    write_reg(REG_LEAD_MAX, lmax);
    cfg_we <= 1'b0;
  endtask

  function automatic logic [TimeW-1:0] pick_time(cfg_reg_t lo, cfg_reg_t hi);
    if (int'(thr[hi]) > int'(thr[lo]) + 1) begin
      return 16'($urandom_range(int'(thr[hi]) - 1, int'(thr[lo]) + 1));
    end
    return 16'($urandom);
  endfunction

  task automatic send_noise(int n);
    cfg_reg_t lo;
    for (int i = 0; i < n; i++) begin
      lo = cfg_reg_t'(2 * $urandom_range(3));
      if ($urandom_range(1)) begin
        send_event(op_t'($urandom_range(3)), 16'($urandom));
      end else begin
        send_event(op_t'($urandom_range(3)), pick_time(lo, cfg_reg_t'(lo + 1)));
      end
    end
  endtask

  // lead pulse, 32 bit pulses MSB first, a read, then some repeat codes
  task automatic send_frame();
    logic [31:0] frame;
    logic [7:0]  addr;
    logic [7:0]  data;
    int          mode;
    addr = 8'($urandom);
    data = 8'($urandom);
    mode = $urandom_range(9);
    frame = {addr, ~addr, data, ~data};
    if (mode == 7) frame[23:16] = 8'($urandom);
    if (mode == 8) frame[7:0]   = 8'($urandom);
    if (mode == 9) frame        = $urandom;
    send_pulse(pick_time(REG_LEAD_MIN, REG_LEAD_MAX));
    for (int b = 31; b >= 0; b--) begin
      if ($urandom_range(99) < 4) send_event(OP_TICK, 16'($urandom));
      if ($urandom_range(99) < 2) send_noise(1);
      if (frame[b]) begin
        send_pulse(pick_time(REG_ONE_MIN, REG_ONE_MAX));
      end else begin
        send_pulse(pick_time(REG_ZERO_MIN, REG_ZERO_MAX));
      end
    end
    send_event(OP_READ, 16'($urandom));
    repeat ($urandom_range(4)) begin
      repeat ($urandom_range(3)) send_event(OP_TICK, 16'($urandom));
      send_pulse(pick_time(REG_REPEAT_MIN, REG_REPEAT_MAX));
      send_event(OP_READ, 16'($urandom));
    end
  endtask

  // repeat codes and tick runs long enough to hit the timeout
  task automatic send_repeat_burst();
    send_pulse(pick_time(REG_LEAD_MIN, REG_LEAD_MAX));
    repeat ($urandom_range(1, 4)) begin
      if ($urandom_range(3) != 0) send_pulse(pick_time(REG_REPEAT_MIN, REG_REPEAT_MAX));
      repeat ($urandom_range(16)) send_event(OP_TICK, 16'($urandom));
      send_event(OP_READ, 16'($urandom));
    end
  endtask

  task automatic test_directed_events();
    send_event(OP_READ, 16'h0000);      // all-zero frame fails both checks
    send_event(OP_TICK, 16'hffff);      // tick with no lead: no effect
    send_event(OP_FALL, 16'd4500);      // falling edge not armed
    send_event(OP_RISE, 16'h0000);
    send_event(OP_RISE, 16'hffff);      // stays armed
    send_event(OP_FALL, 16'd4500);      // lead
    send_pulse(16'd550);                // zero
    send_pulse(16'd1650);               // one
    send_pulse(16'd2500);               // repeat
    send_pulse(16'd0);                  // matches no class
    send_pulse(16'd65535);
    send_pulse(16'd400);                // bounds are exclusive
    send_pulse(16'd1800);
    send_event(OP_RISE, 16'h0000);
    send_event(OP_TICK, 16'h0000);      // tick with lead drops the arm
    send_event(OP_FALL, 16'd550);
    send_event(OP_READ, 16'hffff);      // bad data byte clears lead
    send_event(OP_READ, 16'h0000);
    send_pulse(16'd4300);
    send_pulse(16'd4700);
  endtask

  task automatic test_random_traffic(int n_items, int in_pct, int out_pct);
    int stop_at;
    int kind;
    in_idle_pct  = in_pct;
    out_idle_pct = out_pct;
    stop_at      = items_sent + n_items;
    while (items_sent < stop_at) begin
      kind = $urandom_range(99);
      if (kind < 55) begin
        send_frame();
      end else if (kind < 72) begin
        send_repeat_burst();
      end else begin
        send_noise($urandom_range(1, 10));
      end
    end
  endtask

  task automatic test_extreme_thresholds();
    logic [TimeW-1:0] lo [4];
    logic [TimeW-1:0] hi [4];
    in_idle_pct  = 0;
    out_idle_pct = 0;
    load_thresholds('0, '0, '0, '0, '0, '0, '0, '0);
    send_noise(30);
    wait_idle();
    load_thresholds('1, '1, '1, '1, '1, '1, '1, '1);
    send_noise(30);
    wait_idle();
    for (int i = 0; i < 4; i++) begin
      lo[i] = 16'($urandom_range(62000));
      hi[i] = lo[i] + 16'($urandom_range(2, 3000));
    end
    load_thresholds(lo[0], hi[0], lo[1], hi[1], lo[2], hi[2], lo[3], hi[3]);
    test_random_traffic(100, 10, 10);
    wait_idle();
  endtask

  task automatic test_backpressure();
    in_idle_pct  = 0;
    out_idle_pct = 0;
    hold_request = LONG_HOLD;
    send_frame();
    wait_idle();
  endtask

  initial begin
    thr[REG_ZERO_MIN]   = ZERO_MIN_RST;
    thr[REG_ZERO_MAX]   = ZERO_MAX_RST;
    thr[REG_ONE_MIN]    = ONE_MIN_RST;
    thr[REG_ONE_MAX]    = ONE_MAX_RST;
    thr[REG_REPEAT_MIN] = REPEAT_MIN_RST;
    thr[REG_REPEAT_MAX] = REPEAT_MAX_RST;
    thr[REG_LEAD_MIN]   = LEAD_MIN_RST;
    thr[REG_LEAD_MAX]   = LEAD_MAX_RST;
    lead_flag     = 1'b0;
    edge_armed    = 1'b0;
    timeout_ticks = '0;
    frame_shift   = '0;
    repeat_count  = '0;
    repeat (5) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    test_directed_events();
    test_random_traffic(250, 26, 53);
    wait_idle();
    // overlapping windows, lead window at the range limits
    load_thresholds(16'd0, 16'd1000, 16'd500, 16'd2000,
                    16'd1500, 16'd3000, 16'd0, 16'd65535);
    test_random_traffic(250, 53, 26);
    wait_idle();
    test_extreme_thresholds();
    load_thresholds(ZERO_MIN_RST, ZERO_MAX_RST, ONE_MIN_RST, ONE_MAX_RST,
                    REPEAT_MIN_RST, REPEAT_MAX_RST, LEAD_MIN_RST, LEAD_MAX_RST);
    test_backpressure();
    test_random_traffic(100, 0, 0);
    wait_idle();

    if (mismatches == 0 && pending_results.size() == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

endmodule
